FILE: sv/lif_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types and constants of the toroidal life board.
// ----------------------------------------------------------------------------
package lif_pkg;

    localparam int ACTION_W    = 2;
    localparam int ROW_INDEX_W = 5;
    localparam int ROW_BITS_W  = 24;
    localparam int NBR_CNT_W   = 4;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

    localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [NBR_CNT_W-1:0] STAY_COUNT  = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_POST
    } state_t;

endpackage
`default_nettype wire

FILE: sv/lif_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_cell
// One lane: counts the eight neighbours of a cell and applies the life rule.
// ----------------------------------------------------------------------------
module lif_cell (
    input  wire logic [7:0] nbrs,
    input  wire logic       alive,
    output logic            next_alive
);
    import lif_pkg::*;

    logic [NBR_CNT_W-1:0] cnt;

    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + NBR_CNT_W'(nbrs[i]);
        end
        next_alive = (cnt == BIRTH_COUNT) || ((cnt == STAY_COUNT) && alive);
    end

endmodule
`default_nettype wire

FILE: sv/lif_rowcalc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lif_rowcalc
// One cell lane per column over a three-row window; the lane results are
// merged into the next generation of the middle row.
// ----------------------------------------------------------------------------
module lif_rowcalc #(
    parameter int COLS = 24
) (
    input  wire logic [COLS-1:0] above_row,
    input  wire logic [COLS-1:0] mid_row,
    input  wire logic [COLS-1:0] below_row,
    output logic      [COLS-1:0] next_row
);
    import lif_pkg::*;

    for (genvar j = 0; j < COLS; j++)
    begin : g_lane
        localparam int L = (j + COLS - 1) % COLS;
        localparam int R = (j + 1) % COLS;

        logic [7:0] nbrs;
        logic       lane_out;

        assign nbrs = {above_row[L], above_row[j], above_row[R],
                       mid_row[L], mid_row[R],
                       below_row[L], below_row[j], below_row[R]};

        lif_cell u_cell (
            .nbrs       (nbrs),
            .alive      (mid_row[j]),
            .next_alive (lane_out)
        );

        assign next_row[j] = lane_out;
    end

endmodule
`default_nettype wire

FILE: sv/life_automaton_torus.sv
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_torus
// ROWS by COLS toroidal life board with row write, row read and advance.
// ----------------------------------------------------------------------------
// One word is taken at a time. A row write or read passes through the post
// state, which moves its result into the output register once that register
// is empty or being taken. An advance first sweeps the whole board and then
// passes through the post state in the same way. The board sits in a memory
// with one read and one write port, so the sweep reads one row per cycle
// into a rolling three-row window, the column lanes form the new row and it
// is written back in place. The input side is ready again once the result
// sits in the output register, so a new word may enter while the previous
// result still waits to be taken. Rows never written since reset read as
// dead through per-row valid bits.
// ----------------------------------------------------------------------------
module life_automaton_torus #(
    parameter int COLS = 24,
    parameter int ROWS = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [lif_pkg::ACTION_W-1:0]    action,
    input  wire logic [lif_pkg::ROW_INDEX_W-1:0] row_index,
    input  wire logic [lif_pkg::ROW_BITS_W-1:0]  row_bits,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [lif_pkg::ROW_BITS_W-1:0]  read_bits,
    output logic      [lif_pkg::ACTION_W-1:0]    done_action
);
    import lif_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int SW = $clog2(ROWS + 3);
    localparam logic [SW-1:0] SEQ_LAST  = SW'(ROWS + 2);
    localparam logic [SW-1:0] SEQ_RDEND = SW'(ROWS);
    localparam logic [SW-1:0] SEQ_DEND  = SW'(ROWS + 1);
    localparam logic [SW-1:0] SEQ_ROW0  = SW'(2);
    localparam logic [SW-1:0] SEQ_WR0   = SW'(3);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    logic [COLS-1:0] cell_mem [ROWS];

    state_t                 state_reg, state_next;
    logic [SW-1:0]          seq_reg, seq_next;
    logic [ACTION_W-1:0]    act_reg;
    logic                   read_ok_reg;
    logic [COLS-1:0]        rd_data_reg;
    logic                   rd_valid_reg;
    logic [ROWS-1:0]        row_valid_reg;
    logic [COLS-1:0]        win_a_reg, win_b_reg, row0_reg;
    logic                   out_valid_reg;
    logic [ROW_BITS_W-1:0]  read_bits_reg;
    logic [ACTION_W-1:0]    done_action_reg;

    logic                   accept;
    logic                   in_range;
    logic                   rd_en, wr_en, post_ok, shift_en;
    logic [RW-1:0]          rd_addr, wr_addr;
    logic [COLS-1:0]        wr_data;
    logic [COLS-1:0]        row_in, below_row, new_row;
    logic [ROW_BITS_W-1:0]  post_bits;

    assign accept    = in_valid && in_ready;
    assign in_range  = 32'(row_index) < ROWS;
    assign row_in    = rd_valid_reg ? rd_data_reg : '0;
    assign below_row = (seq_reg == SEQ_LAST) ? row0_reg : row_in;
    assign post_ok   = !out_valid_reg || out_ready;
    assign post_bits = (act_reg == ACT_READ && read_ok_reg && rd_valid_reg)
                       ? ROW_BITS_W'(rd_data_reg) : '0;

    lif_rowcalc #(
        .COLS (COLS)
    ) u_rowcalc (
        .above_row (win_a_reg),
        .mid_row   (win_b_reg),
        .below_row (below_row),
        .next_row  (new_row)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                seq_next = '0;
                if (in_valid)
                begin
                    state_next = (action == ACT_STEP) ? ST_SWEEP : ST_POST;
                end
            end
            ST_SWEEP:
            begin
                seq_next = seq_reg + SW'(1);
                if (seq_reg == SEQ_LAST)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (post_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and memory port control
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = RW'(row_index);
        wr_en    = 1'b0;
        wr_addr  = RW'(row_index);
        wr_data  = COLS'(row_bits);
        shift_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid && action == ACT_READ && in_range;
                wr_en    = in_valid && action == ACT_WRITE && in_range;
            end
            ST_SWEEP:
            begin
                rd_en    = seq_reg <= SEQ_RDEND;
                rd_addr  = (seq_reg == '0) ? LAST_ROW : RW'(seq_reg - SW'(1));
                wr_en    = seq_reg >= SEQ_WR0;
                wr_addr  = RW'(seq_reg - SEQ_WR0);
                wr_data  = new_row;
                shift_en = seq_reg != '0 && seq_reg <= SEQ_DEND;
            end
            ST_POST:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seq_reg       <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
            if (state_reg == ST_POST && post_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= action;
            read_ok_reg <= in_range;
        end
        if (shift_en)
        begin
            win_a_reg <= win_b_reg;
            win_b_reg <= row_in;
            if (seq_reg == SEQ_ROW0)
            begin
                row0_reg <= row_in;
            end
        end
        if (state_reg == ST_POST && post_ok)
        begin
            read_bits_reg   <= post_bits;
            done_action_reg <= act_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_bits   = read_bits_reg;
    assign done_action = done_action_reg;

    a_sweep_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && rd_en && wr_en) |-> rd_addr != wr_addr)
        else $error("sweep reads and writes the same row");

    a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> seq_reg <= SEQ_LAST)
        else $error("sweep counter overran");

    a_result_from_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_POST))
        else $error("result posted outside post state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SWEEP || state_reg == ST_POST))
        else $error("accepted word not processed");

endmodule
`default_nettype wire
